@@ rtl/core/mucl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mucl_pkg
// Types and constants shared by the multicast UDP flow classifier.
// ----------------------------------------------------------------------------
package mucl_pkg;

    typedef struct packed {
        logic [7:0] hdr_byte;
        logic       byte_last;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  flow_index;
        logic [19:0] flow_packet_count;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [4:0]  flows_in_use;
        logic [19:0] packets_counted;
        logic        limit_reached;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
    } flow_key_t;

    typedef struct packed {
        logic      mc_udp;
        flow_key_t key;
    } hdr_info_t;

    // result status codes
    localparam logic [2:0] ST_NOT_MC  = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_NEW     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [19:0] PACKET_LIMIT_RST = 20'h10000;

    // header layout
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
    localparam logic [7:0]  IP_MIN_HDR     = 8'd20;
    localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;
    localparam logic [7:0]  MIN_PKT_LEN    = 8'd42;
    localparam logic [7:0]  OFS_ETYPE_HI   = 8'd12;
    localparam logic [7:0]  OFS_ETYPE_LO   = 8'd13;
    localparam logic [7:0]  OFS_IP_VER_IHL = 8'd14;
    localparam logic [7:0]  OFS_IP_PROTO   = 8'd23;
    localparam logic [7:0]  OFS_SRC_IP     = 8'd26;
    localparam logic [7:0]  OFS_DST_IP     = 8'd30;
    localparam logic [7:0]  IP_ADDR_BYTES  = 8'd4;
    localparam logic [7:0]  UDP_PORT_BYTES = 8'd4;

    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [3:0]  IHL_MASK       = 4'hf;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [31:0] MC_MASK        = 32'hf000_0000;
    localparam logic [31:0] MC_PREFIX      = 32'he000_0000;

endpackage

@@ rtl/core/mucl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mucl_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mucl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/mucl_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mucl_parser
// Byte position counter and header field capture; qualifies the packet as
// IPv4 multicast UDP once the last beat is in.
// ----------------------------------------------------------------------------
module mucl_parser #(
    parameter int HEADER_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat_en,
    input  mucl_pkg::in_beat_t  beat,
    output mucl_pkg::hdr_info_t hdr
);
    import mucl_pkg::*;

    localparam int POS_W = $clog2(HEADER_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next, pos_inc;
    logic [POS_W-1:0] len_reg;
    logic [15:0]      etype_reg;
    logic [5:0]       ihl4_reg;
    logic [7:0]       proto_reg;
    logic [31:0]      sip_reg;
    logic [31:0]      dip_reg;
    logic [31:0]      ports_reg;

    logic [7:0] pos8, len8, ihl8, port_base;

    assign pos8      = 8'(pos_reg);
    assign len8      = 8'(len_reg);
    assign ihl8      = {2'b00, ihl4_reg};
    assign port_base = ETH_HDR_LEN + ihl8;

    // counter sticks at HEADER_BYTES; later bytes are dropped
    assign pos_inc  = (pos_reg < POS_W'(HEADER_BYTES)) ? pos_reg + POS_W'(1) : pos_reg;
    assign pos_next = beat.byte_last ? '0 : pos_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (beat_en)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_en)
        begin
            if (beat.byte_last)
            begin
                len_reg <= pos_inc;
            end
            if (pos8 == OFS_ETYPE_HI)
            begin
                etype_reg[15:8] <= beat.hdr_byte;
            end
            if (pos8 == OFS_ETYPE_LO)
            begin
                etype_reg[7:0] <= beat.hdr_byte;
            end
            if (pos8 == OFS_IP_VER_IHL)
            begin
                ihl4_reg <= {beat.hdr_byte[3:0] & IHL_MASK, 2'b00};
            end
            if (pos8 == OFS_IP_PROTO)
            begin
                proto_reg <= beat.hdr_byte;
            end
            if (pos8 >= OFS_SRC_IP && pos8 < OFS_SRC_IP + IP_ADDR_BYTES)
            begin
                sip_reg <= {sip_reg[23:0], beat.hdr_byte};
            end
            if (pos8 >= OFS_DST_IP && pos8 < OFS_DST_IP + IP_ADDR_BYTES)
            begin
                dip_reg <= {dip_reg[23:0], beat.hdr_byte};
            end
            // UDP ports follow the variable-length IP header
            if (pos8 >= port_base && pos8 < port_base + UDP_PORT_BYTES)
            begin
                ports_reg <= {ports_reg[23:0], beat.hdr_byte};
            end
        end
    end

    always_comb
    begin
        hdr.mc_udp = (len8 >= MIN_PKT_LEN) &&
                     (etype_reg == ETH_IPV4) &&
                     (ihl8 >= IP_MIN_HDR) &&
                     (len8 >= port_base + UDP_HDR_LEN) &&
                     (proto_reg == PROTO_UDP) &&
                     ((dip_reg & MC_MASK) == MC_PREFIX);
        hdr.key.src_ip   = sip_reg;
        hdr.key.src_port = ports_reg[31:16];
        hdr.key.dst_ip   = dip_reg;
        hdr.key.dst_port = ports_reg[15:0];
    end

endmodule

@@ rtl/core/mucl_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mucl_search
// Flow table sequencer: walks the filled entries through one key comparator,
// then counts, inserts or drops the packet and builds the result.
// ----------------------------------------------------------------------------
module mucl_search #(
    parameter int FLOW_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mucl_pkg::hdr_info_t hdr,
    input  logic [19:0]         packet_limit,
    input  logic                out_free,
    output logic                busy,
    output logic                res_valid,
    output mucl_pkg::out_beat_t res
);
    import mucl_pkg::*;

    localparam int IDX_W  = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int FILL_W = $clog2(FLOW_ENTRIES + 1);
    localparam int KEY_W  = $bits(flow_key_t);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [19:0]       total_reg, total_next;
    logic              trunc_reg, trunc_next;
    logic [2:0]        status_reg, status_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [19:0]       base_reg, base_next;

    logic [KEY_W-1:0]  key_rd;
    logic [19:0]       cnt_rd;
    logic              key_hit;
    logic              counted;
    logic              commit;
    logic [19:0]       cnt_new;
    logic [19:0]       total_inc;
    logic              table_full;
    logic [FILL_W-1:0] j_plus;
    logic              show_tuple;

    mucl_ram #(
        .WIDTH(KEY_W),
        .DEPTH(FLOW_ENTRIES)
    ) u_key_ram (
        .clk    (clk),
        .wr_en  (commit && (status_reg == ST_NEW)),
        .wr_addr(slot_reg),
        .wr_data(hdr.key),
        .rd_addr(j_reg),
        .rd_data(key_rd)
    );

    mucl_ram #(
        .WIDTH(20),
        .DEPTH(FLOW_ENTRIES)
    ) u_cnt_ram (
        .clk    (clk),
        .wr_en  (commit && counted),
        .wr_addr(slot_reg),
        .wr_data(cnt_new),
        .rd_addr(j_reg),
        .rd_data(cnt_rd)
    );

    // the shared comparator
    assign key_hit    = (key_rd == hdr.key);
    assign table_full = (fill_reg == FILL_W'(FLOW_ENTRIES));
    assign j_plus     = FILL_W'(j_reg) + FILL_W'(1);
    assign counted    = (status_reg == ST_MATCH) || (status_reg == ST_NEW);
    assign commit     = (state_reg == S_DONE) && out_free;
    assign cnt_new    = base_reg + 20'd1;
    assign total_inc  = total_reg + 20'd1;
    assign show_tuple = counted || (status_reg == ST_FULL);

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = commit;

    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        fill_next   = fill_reg;
        total_next  = total_reg;
        trunc_next  = trunc_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        base_next   = base_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                j_next    = '0;
                slot_next = '0;
                base_next = '0;
                priority if (trunc_reg)
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else if (!hdr.mc_udp)
                begin
                    status_next = ST_NOT_MC;
                    state_next  = S_DONE;
                end
                else if (fill_reg == '0)
                begin
                    status_next = table_full ? ST_FULL : ST_NEW;
                    slot_next   = table_full ? '0 : fill_reg[IDX_W-1:0];
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (key_hit)
                begin
                    status_next = ST_MATCH;
                    slot_next   = j_reg;
                    base_next   = cnt_rd;
                    state_next  = S_DONE;
                end
                else if (j_plus < fill_reg)
                begin
                    j_next     = j_plus[IDX_W-1:0];
                    state_next = S_READ;
                end
                else
                begin
                    status_next = table_full ? ST_FULL : ST_NEW;
                    slot_next   = table_full ? '0 : fill_reg[IDX_W-1:0];
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (counted)
                    begin
                        total_next = total_inc;
                        if (total_inc >= packet_limit)
                        begin
                            trunc_next = 1'b1;
                        end
                    end
                    if (status_reg == ST_NEW)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status            = status_reg;
        res.flow_index        = counted ? 4'(slot_reg) : 4'd0;
        res.flow_packet_count = counted ? cnt_new : 20'd0;
        res.src_ip            = show_tuple ? hdr.key.src_ip : 32'd0;
        res.src_port          = show_tuple ? hdr.key.src_port : 16'd0;
        res.dst_ip            = show_tuple ? hdr.key.dst_ip : 32'd0;
        res.dst_port          = show_tuple ? hdr.key.dst_port : 16'd0;
        res.flows_in_use      = 5'(fill_next);
        res.packets_counted   = total_next;
        res.limit_reached     = trunc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            total_reg <= '0;
            trunc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            trunc_reg <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        base_reg   <= base_next;
    end

endmodule

@@ rtl/core/multicast_udp_flow_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicast_udp_flow_classifier
// Classifies captured packet headers as IPv4 multicast UDP and keeps a flow
// table of source and destination address and port with per-flow counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one captured header byte per beat, byte_last on the final byte.
//           Non-final bytes are taken one per cycle while in_stall is low.
//   out_* : one result beat per packet, after its final byte.
//   cfg_* : writes packet_limit; always ready, write only while idle.
// Search: after the final byte the sequencer steps through S_CHECK,
//   then S_READ and S_CMP for each of the N entries compared (at most
//   the entries in use), then S_DONE; the table walk reads one entry at
//   a time through the registered RAM port and a single key comparator.
//   in_stall stays high during that walk.
// Reset clears the byte counter, fill count, packet total and the
//   truncated flag; the table needs no clearing pass.
// When out_stall holds a result, the next packet's bytes are still taken;
//   its final byte waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module multicast_udp_flow_classifier #(
    parameter int FLOW_ENTRIES = 16,
    parameter int HEADER_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mucl_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mucl_pkg::out_beat_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [19:0]         cfg_data
);
    import mucl_pkg::*;

    logic        beat_en;
    logic        busy;
    logic        res_valid;
    out_beat_t   res;
    hdr_info_t   hdr;
    logic        out_free;
    logic [19:0] limit_reg;
    logic        out_valid_reg;
    out_beat_t   out_data_reg;

    assign in_stall  = busy;
    assign beat_en   = in_valid && !busy;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    mucl_parser #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .beat_en(beat_en),
        .beat   (in_data),
        .hdr    (hdr)
    );

    mucl_search #(
        .FLOW_ENTRIES(FLOW_ENTRIES)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (beat_en && in_data.byte_last),
        .hdr         (hdr),
        .packet_limit(limit_reg),
        .out_free    (out_free),
        .busy        (busy),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= PACKET_LIMIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
